// File: src/wep_pkg.sv
// Shared types and constants for the weighted entering-candidate pricer.
`timescale 1ns / 1ps

package wep_pkg;

	// Stream widths
	localparam int InDataW  = 88;
	localparam int InUserW  = 4;
	localparam int OutDataW = 16;
	localparam int OutUserW = 3;
	localparam int TolW     = 31;

	// Queue between front and back
	localparam int QDepth = 4;
	localparam int QPtrW  = 2;
	localparam int QCntW  = 3;

	// Basis status codes
	localparam logic [2:0] ST_LOWER = 3'd0;
	localparam logic [2:0] ST_UPPER = 3'd1;
	localparam logic [2:0] ST_FREE  = 3'd2;
	localparam logic [2:0] ST_BOTH  = 3'd3;

	localparam logic signed [33:0] FactorOne = 34'sd65536;
	localparam logic signed [63:0] ScoreMax  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] ScoreMin  = 64'sh8000_0000_0000_0000;

	// What the back end does with a queued request
	typedef enum logic [1:0] {
		OP_SCORE,
		OP_FREE,
		OP_ERR,
		OP_LAST
	} wep_op_t;

	typedef enum logic [1:0] {
		RES_SEL     = 2'd0,
		RES_NONE    = 2'd1,
		RES_INVALID = 2'd2
	} wep_res_t;

	typedef struct packed {
		wep_op_t     op;
		logic        row;
		logic [15:0] idx;
		logic        last;
	} wep_tag_t;

	typedef struct packed {
		wep_tag_t           tag;
		logic [31:0]        mag;
		logic signed [33:0] fac;
	} wep_item_t;

endpackage

// File: src/wep_front.sv
// Front end: take candidates, test eligibility, classify status, form |t| and factor.
`timescale 1ns / 1ps

module wep_front #(
	parameter int INDEX_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [wep_pkg::InDataW-1:0] s_tdata,
	input  logic [wep_pkg::InUserW-1:0] s_tuser,
	input  logic                        s_tlast,
	input  logic [wep_pkg::TolW-1:0]    tol,
	input  logic                        q_full,
	output logic                        push,
	output wep_pkg::wep_item_t          push_item
);
	import wep_pkg::*;

	localparam int IdxW = (INDEX_BITS > 16) ? 16 : INDEX_BITS;
	localparam logic [15:0] IdxMask = 16'((17'd1 << IdxW) - 17'd1);

	logic               fin_q;
	logic               take;
	logic               elig;
	logic signed [31:0] t;
	logic signed [31:0] p;
	logic [2:0]         status;
	logic signed [32:0] neg_tol;
	logic signed [33:0] p_ext;
	logic               use_plus;
	wep_op_t            op;

	assign t       = s_tdata[31:0];
	assign p       = s_tdata[63:32];
	assign status  = s_tuser[2:0];
	assign neg_tol = -$signed({2'b00, tol});
	assign elig    = $signed({t[31], t}) < neg_tol;
	assign p_ext   = {{2{p[31]}}, p};

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	always_comb begin
		use_plus = 1'b1;
		op       = OP_SCORE;
		unique case (status)
			ST_LOWER: use_plus = 1'b1;
			ST_UPPER: use_plus = 1'b0;
			ST_BOTH:  use_plus = s_tdata[64];
			ST_FREE:  op = OP_FREE;
			default:  op = OP_ERR;
		endcase
		if (!elig) begin
			op = OP_LAST;
		end
	end

	always_comb begin
		push_item.tag.op   = op;
		push_item.tag.row  = s_tuser[3];
		push_item.tag.idx  = s_tdata[80:65] & IdxMask;
		push_item.tag.last = s_tlast;
		push_item.mag      = t[31] ? (~t + 32'd1) : t;
		push_item.fac      = use_plus ? (FactorOne + p_ext) : (FactorOne - p_ext);
	end

	// Drop ineligible items that do not end the scan, and all items of a finished scan.
	assign push = take && !fin_q && (elig || s_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
		end else if (take) begin
			if (fin_q) begin
				if (s_tlast) begin
					fin_q <= 1'b0;
				end
			end else if (elig && (op == OP_FREE || op == OP_ERR) && !s_tlast) begin
				fin_q <= 1'b1;
			end
		end
	end

endmodule

// File: src/wep_queue.sv
// Short request queue between the front and back ends.
`timescale 1ns / 1ps

module wep_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wep_pkg::wep_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output wep_pkg::wep_item_t pop_item
);
	import wep_pkg::*;

	wep_item_t        slot_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_pop;

	assign full     = cnt_q == QCntW'(QDepth);
	assign empty    = cnt_q == '0;
	assign pop_item = slot_q[rd_q];
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPtrW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPtrW'(1);
			end
			cnt_q <= cnt_q + QCntW'(push) - QCntW'(do_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("queue count beyond depth");
`endif

endmodule

// File: src/wep_back.sv
// Back end: score pipeline, running minimum and result register.
`timescale 1ns / 1ps

module wep_back #(
	parameter int INDEX_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  wep_pkg::wep_item_t           q_item,
	output logic                         q_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [wep_pkg::OutDataW-1:0] m_tdata,
	output logic [wep_pkg::OutUserW-1:0] m_tuser
);
	import wep_pkg::*;

	localparam int IdxW = (INDEX_BITS > 16) ? 16 : INDEX_BITS;

	logic adv;

	// Stage registers
	logic               v_s1, v_s2, v_s3, v_s4;
	wep_tag_t           tag_s1, tag_s2, tag_s3, tag_s4;
	logic [63:0]        sq_s1;
	logic [31:0]        fmag_s1;
	logic               neg_s1, neg_s2, neg_s3;
	logic [63:0]        plo_s2, phh_s2;
	logic [63:0]        phi_s3;
	logic [31:0]        plo_s3;
	logic signed [63:0] score_s4;

	// Running best
	logic signed [63:0] best_score_q;
	logic [IdxW-1:0]    best_idx_q;
	logic               best_row_q;
	logic               have_q;

	logic               m_tvalid_q;
	logic [15:0]        m_idx_q;
	logic               m_row_q;
	wep_res_t           m_code_q;

	// Final stage decisions
	logic               upd;
	logic               nx_have;
	logic [IdxW-1:0]    nx_idx;
	logic               nx_row;
	logic               emit;
	logic               clr;
	wep_res_t           e_code;
	logic               e_row;
	logic [15:0]        e_idx;

	logic [32:0]        fmag_w;
	logic               sat;
	logic [63:0]        q_w;
	logic               rem;
	logic signed [63:0] score_w;

	assign adv   = !m_tvalid_q || m_tready;
	assign q_pop = adv && !q_empty;

	assign fmag_w = q_item.fac[33] ? 33'(-q_item.fac) : 33'(q_item.fac);

	always_comb begin
		sat = |phi_s3[63:47];
		q_w = {phi_s3[47:0], plo_s3[31:16]};
		rem = |plo_s3[15:0];
		if (sat) begin
			score_w = neg_s3 ? ScoreMin : ScoreMax;
		end else if (neg_s3) begin
			score_w = rem ? $signed(~q_w) : $signed(~q_w + 64'd1);
		end else begin
			score_w = $signed(q_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1   <= q_item.tag;
			sq_s1    <= q_item.mag * q_item.mag;
			fmag_s1  <= fmag_w[31:0];
			neg_s1   <= !q_item.fac[33];
			tag_s2   <= tag_s1;
			plo_s2   <= sq_s1[31:0] * fmag_s1;
			phh_s2   <= sq_s1[63:32] * fmag_s1;
			neg_s2   <= neg_s1;
			tag_s3   <= tag_s2;
			phi_s3   <= phh_s2 + {32'd0, plo_s2[63:32]};
			plo_s3   <= plo_s2[31:0];
			neg_s3   <= neg_s2;
			tag_s4   <= tag_s3;
			score_s4 <= score_w;
		end
	end

	always_comb begin
		upd     = 1'b0;
		emit    = 1'b0;
		clr     = 1'b0;
		e_code  = RES_SEL;
		e_row   = tag_s4.row;
		e_idx   = tag_s4.idx;
		if (tag_s4.op == OP_SCORE) begin
			upd = !have_q || (score_s4 < best_score_q);
		end
		nx_have = have_q || upd;
		nx_idx  = upd ? tag_s4.idx[IdxW-1:0] : best_idx_q;
		nx_row  = upd ? tag_s4.row : best_row_q;
		if (v_s4) begin
			unique case (tag_s4.op)
				OP_FREE: begin
					emit = 1'b1;
				end
				OP_ERR: begin
					emit   = 1'b1;
					e_code = RES_INVALID;
				end
				OP_SCORE, OP_LAST: begin
					emit   = tag_s4.last;
					e_code = nx_have ? RES_SEL : RES_NONE;
					e_row  = nx_have && nx_row;
					e_idx  = nx_have ? 16'(nx_idx) : 16'd0;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
			clr = emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= ScoreMax;
			best_idx_q   <= '0;
			best_row_q   <= 1'b0;
			have_q       <= 1'b0;
		end else if (adv && v_s4) begin
			if (clr) begin
				best_score_q <= ScoreMax;
				best_idx_q   <= '0;
				best_row_q   <= 1'b0;
				have_q       <= 1'b0;
			end else if (upd) begin
				best_score_q <= score_s4;
				best_idx_q   <= nx_idx;
				best_row_q   <= nx_row;
				have_q       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= v_s4 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4 && emit) begin
			m_code_q <= e_code;
			m_row_q  <= e_row;
			m_idx_q  <= e_idx;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_idx_q;
	assign m_tuser  = {m_row_q, m_code_q};

`ifndef NO_ASSERTIONS
	a_rise_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(v_s4 && adv))
		else $error("result raised without a finishing request");
	a_empty_best: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> (best_score_q == ScoreMax && best_idx_q == '0 && !best_row_q))
		else $error("best state not clear while empty");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (v_s4 == $past(v_s4) && have_q == $past(have_q)))
		else $error("back end moved while the result was stalled");
`endif

endmodule

// File: src/weighted_enter_pricer.sv
// Top level of the weighted entering-candidate pricer.
`timescale 1ns / 1ps

// Weighted entering-candidate pricer.
// Candidates stream in on the s_ channel, one request per candidate; s_tlast
// marks the final candidate of a scan. Eligible candidates (test value below
// minus the tolerance) get the score -t*t*(1+/-p) in Q32.32, saturated; the
// lowest score wins, earlier candidates winning ties. On the last candidate
// one result leaves on the m_ channel: the winner, or "no eligible" code.
// A free or invalid-status eligible candidate is reported at once and the
// rest of that scan is dropped without results.
// The user must write the tolerance register on the cfg_ channel only while
// the block idles; the block does not enforce it. Throughput: one candidate
// per cycle while the receiver does not stall, set by the queue and the
// five-stage back-end pipeline (square, two partial products, carry merge,
// score form, then compare into the running best in the same cycle as the
// result load). When the receiver stalls the back end holds; the four-entry
// queue absorbs incoming requests until it fills, then s_tready drops.
// Reset: tolerance returns to 66, the scan state is empty, no clearing pass.
module weighted_enter_pricer #(
	parameter int INDEX_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Tolerance write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [wep_pkg::TolW-1:0]     cfg_data,
	// Candidate stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [31:0] test_value, [63:32] penalty, [64] above_bound, [80:65] cand_index,
	// [87:81] zero
	input  logic [wep_pkg::InDataW-1:0]  s_tdata,
	// [2:0] basis_status, [3] cand_is_row
	input  logic [wep_pkg::InUserW-1:0]  s_tuser,
	input  logic                         s_tlast,
	// Result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [15:0] sel_index
	output logic [wep_pkg::OutDataW-1:0] m_tdata,
	// [1:0] result_code, [2] sel_is_row
	output logic [wep_pkg::OutUserW-1:0] m_tuser
);
	import wep_pkg::*;

	logic [TolW-1:0] tol_q;
	logic            q_full;
	logic            q_empty;
	logic            push;
	logic            pop;
	wep_item_t       push_item;
	wep_item_t       pop_item;

	// Tolerance register; always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TolW'(66);
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// Classify and drop candidates
	wep_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.tol      (tol_q),
		.q_full   (q_full),
		.push     (push),
		.push_item(push_item)
	);

	// Decouple classification from scoring
	wep_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.pop_item (pop_item)
	);

	// Score, keep the minimum, report
	wep_back #(
		.INDEX_BITS(INDEX_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (pop_item),
		.q_pop   (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
